// ===== hw/rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// shared constants and the arctangent table for the quaternion to euler block
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TAB_LEN           = 24;
	localparam int SQRT_STEPS        = 31;
	localparam int QW                = 16;
	localparam int VW                = 32;
	localparam int CW                = 36;
	localparam int AW                = 16;
	localparam int PW                = 15;

	localparam logic signed [CW-1:0] PI_Q30    = 36'sd3373259426;
	localparam logic signed [34:0]   ONE_Q30   = 35'sd1073741824;
	localparam logic signed [18:0]   PI_Q13    = 19'sd25736;
	localparam logic signed [18:0]   HPI_Q13   = 19'sd12868;

	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	function automatic logic signed [VW-1:0] sat_one(input logic signed [34:0] v);
		logic signed [34:0] r;
		r = v;
		if (v > ONE_Q30)
			r = ONE_Q30;
		else if (v < -ONE_Q30)
			r = -ONE_Q30;
		return r[VW-1:0];
	endfunction

endpackage

// ===== hw/rtl/quaternion_to_euler_remapped.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_remapped
// axis-remapped quaternion to roll and yaw in q3.13 and pitch in q2.13 radians
// ----------------------------------------------------------------------------
// slave channel s_*: one request per quaternion, tdata holds x, y, z, w as
// signed q1.15 from the lowest bit up. master channel m_*: one result per
// request with roll, pitch and yaw. the axes are remapped before the angle
// math: a = z, b = x, c = y.
// throughput is one request per cycle while the receiver does not stall.
// the pipeline runs through products, sums, square, radicand, 31 square root
// steps, cordic setup, one stage per cordic iteration, the cordic rounding
// register and the output register.
// reset clears all valid bits; no request is in flight after reset.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_remapped #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // quat_x, quat_y, quat_z, quat_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // roll_angle, pitch_angle, yaw_angle, zero pad
);

	localparam int VW = q2e_pkg::VW;
	localparam int N  = (CORDIC_STAGES > q2e_pkg::TAB_LEN) ? q2e_pkg::TAB_LEN
		: CORDIC_STAGES;
	localparam int SIDE_W = 5 * VW;

	logic en;
	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// stage 1: products
	logic signed [15:0] qa, qb, qc, qw;
	assign qb = s_tdata[15:0];
	assign qc = s_tdata[31:16];
	assign qa = s_tdata[47:32];
	assign qw = s_tdata[63:48];

	logic signed [31:0] wa_s1, bc_s1, aa_s1, bb_s1, wb_s1, ca_s1, wc_s1, ab_s1, cc_s1;
	logic               v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s1 <= qw * qa;
			bc_s1 <= qb * qc;
			aa_s1 <= qa * qa;
			bb_s1 <= qb * qb;
			wb_s1 <= qw * qb;
			ca_s1 <= qc * qa;
			wc_s1 <= qw * qc;
			ab_s1 <= qa * qb;
			cc_s1 <= qc * qc;
		end
	end

	// stage 2: saturated sums
	logic signed [VW-1:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= q2e_pkg::sat_one((35'(wa_s1) + 35'(bc_s1)) <<< 1);
			cr_s2 <= q2e_pkg::sat_one(q2e_pkg::ONE_Q30 - ((35'(aa_s1) + 35'(bb_s1)) <<< 1));
			sp_s2 <= q2e_pkg::sat_one((35'(wb_s1) - 35'(ca_s1)) <<< 1);
			sy_s2 <= q2e_pkg::sat_one((35'(wc_s1) + 35'(ab_s1)) <<< 1);
			cy_s2 <= q2e_pkg::sat_one(q2e_pkg::ONE_Q30 - ((35'(bb_s1) + 35'(cc_s1)) <<< 1));
		end
	end

	// stage 3: sine squared, stage 4: radicand
	logic signed [VW-1:0] sr_s3, cr_s3, sp_s3, sy_s3, cy_s3;
	logic signed [63:0]   sq_full;
	logic [60:0]          sq_s3;
	logic [60:0]          rad_s4;
	logic [SIDE_W-1:0]    side_s4;

	assign sq_full = sp_s2 * sp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= sq_full[60:0];
			sr_s3   <= sr_s2;
			cr_s3   <= cr_s2;
			sp_s3   <= sp_s2;
			sy_s3   <= sy_s2;
			cy_s3   <= cy_s2;
			rad_s4  <= (61'd1 << 60) - sq_s3;
			side_s4 <= {sr_s3, cr_s3, sp_s3, sy_s3, cy_s3};
		end
	end

	// square root and aligned side data
	logic                 sq_vld;
	logic [VW-1:0]        cp_root;
	logic [SIDE_W-1:0]    side_d;

	q2e_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s4),
		.rad     (rad_s4),
		.vld_out (sq_vld),
		.root    (cp_root)
	);

	q2e_delay #(
		.WIDTH (SIDE_W),
		.DEPTH (q2e_pkg::SQRT_STEPS)
	) u_side (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s4),
		.din     (side_s4),
		.vld_out (),
		.dout    (side_d)
	);

	logic signed [VW-1:0] sr_d, cr_d, sp_d, sy_d, cy_d;
	assign {sr_d, cr_d, sp_d, sy_d, cy_d} = side_d;

	logic [1:0] pole_in, pole_d;
	assign pole_in = {sp_d >= VW'(q2e_pkg::ONE_Q30), sp_d <= -VW'(q2e_pkg::ONE_Q30)};

	q2e_delay #(
		.WIDTH (2),
		.DEPTH (N + 2)
	) u_pole (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (sq_vld),
		.din     (pole_in),
		.vld_out (),
		.dout    (pole_d)
	);

	logic                 ang_vld;
	logic signed [15:0]   roll_a, pitch_a, yaw_a;

	q2e_cordic #(.STAGES(CORDIC_STAGES), .LIM(25736)) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (sq_vld),
		.y_in    (sr_d),
		.x_in    (cr_d),
		.vld_out (),
		.angle   (roll_a)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES), .LIM(12868)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (sq_vld),
		.y_in    (sp_d),
		.x_in    (cp_root),
		.vld_out (ang_vld),
		.angle   (pitch_a)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES), .LIM(25736)) u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (sq_vld),
		.y_in    (sy_d),
		.x_in    (cy_d),
		.vld_out (),
		.angle   (yaw_a)
	);

	// output register
	logic [15:0] roll_q, yaw_q;
	logic [14:0] pitch_q;
	logic signed [18:0] pitch_sel;

	always_comb begin
		pitch_sel = 19'(pitch_a);
		if (pole_d[1])
			pitch_sel = q2e_pkg::HPI_Q13;
		else if (pole_d[0])
			pitch_sel = -q2e_pkg::HPI_Q13;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ang_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_a;
			pitch_q <= pitch_sel[14:0];
			yaw_q   <= yaw_a;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, yaw_q, pitch_q, roll_q};

endmodule

// ===== hw/rtl/q2e_delay.sv =====
// ----------------------------------------------------------------------------
// q2e_delay
// stalling shift line that carries side data and its valid bit
// ----------------------------------------------------------------------------
module q2e_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [WIDTH-1:0] din,
	output logic             vld_out,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] dat_q [DEPTH];
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q[0] <= vld_in;
			for (int k = 1; k < DEPTH; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q[0] <= din;
			for (int k = 1; k < DEPTH; k++)
				dat_q[k] <= dat_q[k-1];
		end
	end

	assign vld_out = vld_q[DEPTH-1];
	assign dout    = dat_q[DEPTH-1];

endmodule

// ===== hw/rtl/q2e_sqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module q2e_sqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic [60:0]           rad,
	output logic                  vld_out,
	output logic [q2e_pkg::VW-1:0] root
);

	localparam int N = q2e_pkg::SQRT_STEPS;

	logic [60:0]  n_q [N+1];
	logic [60:0]  r_q [N+1];
	logic [N:0]   v_q;

	assign n_q[0] = rad;
	assign r_q[0] = '0;
	assign v_q[0] = vld_in;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [60:0] BIT = 61'd1 << (60 - 2 * k);
		logic [60:0] trial;
		assign trial = r_q[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_q[k] >= trial) begin
					n_q[k+1] <= n_q[k] - trial;
					r_q[k+1] <= (r_q[k] >> 1) + BIT;
				end else begin
					n_q[k+1] <= n_q[k];
					r_q[k+1] <= r_q[k] >> 1;
				end
			end
		end
	end

	assign vld_out = v_q[N];
	assign root    = r_q[N][q2e_pkg::VW-1:0];

endmodule

// ===== hw/rtl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic atan2, q.30 in, clamped q3.13 out
// ----------------------------------------------------------------------------
module q2e_cordic #(
	parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF,
	parameter int LIM    = 25736
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic signed [q2e_pkg::VW-1:0] y_in,
	input  logic signed [q2e_pkg::VW-1:0] x_in,
	output logic                          vld_out,
	output logic signed [q2e_pkg::AW-1:0] angle
);

	localparam int CW = q2e_pkg::CW;
	localparam int N  = (STAGES > q2e_pkg::TAB_LEN) ? q2e_pkg::TAB_LEN : STAGES;
	localparam logic signed [18:0] LIMV = 19'(LIM);

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [CW-1:0] z_s [N+1];
	logic [N:0]           zero_s;
	logic [N:0]           v_s;
	logic                 v_out_q;

	logic signed [CW-1:0] xe, ye;
	assign xe = CW'(x_in);
	assign ye = CW'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (xe == '0) && (ye == '0);
			if (xe < 0) begin
				x_s[0] <= -xe;
				y_s[0] <= -ye;
				z_s[0] <= (ye >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
			end else begin
				x_s[0] <= xe;
				y_s[0] <= ye;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [CW-1:0] ANG = CW'(q2e_pkg::ATAN_TAB[i]);
		logic signed [CW-1:0] xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ANG;
				end
			end
		end
	end

	logic signed [CW-1:0] zr;
	logic signed [18:0]   zq;
	logic signed [18:0]   zc;
	assign zr = (z_s[N] + CW'(65536)) >>> 17;
	assign zq = zr[18:0];

	always_comb begin
		zc = zq;
		if (zero_s[N])
			zc = '0;
		else if (zq > LIMV)
			zc = LIMV;
		else if (zq < -LIMV)
			zc = -LIMV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			angle <= zc[q2e_pkg::AW-1:0];
	end

	assign vld_out = v_out_q;

endmodule
